// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every enabled edge
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at an edge requires cons at the same edge
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante at an edge requires cons at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rspchk_pkg.sv
// ---------------------------------------------------------------------------
// rspchk_pkg
// Character codes, phase codes, types and the hex digit decoder shared by the
// packet receive checker.
// ---------------------------------------------------------------------------
package rspchk_pkg;

    localparam logic [7:0] CH_START = 8'h24;  // '$'
    localparam logic [7:0] CH_END   = 8'h23;  // '#'
    localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
    localparam logic [7:0] CH_NACK  = 8'h2D;  // '-'

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_HIGH    = 2'd2;
    localparam logic [1:0] PH_LOW     = 2'd3;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] sum;
        logic [3:0] high;
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       is_end;
        logic       ok;
        logic [7:0] sum;
    } t_result;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
            return {1'b0, d[3:0]};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
            return {1'b0, d[3:0]};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
            return {1'b0, d[3:0]};
        end
        return 5'h10;
    endfunction

endpackage

// File: rtl/core/rsp_packet_receive_checker.sv
// ---------------------------------------------------------------------------
// rsp_packet_receive_checker
// Receive side of a remote serial protocol packet, one serial byte per item.
// ---------------------------------------------------------------------------
// One byte is taken per clock cycle while the result register is empty or
// being drained; its result, if any, appears on the master side on the next
// cycle. Bytes before '$' are dropped, payload bytes stream out with the
// running modulo-256 sum, and after '#' two hex digits close the packet with
// a single item that has tlast set and carries '+' (tuser high) or '-'.
// Framing markers and non-hex bytes in the checksum produce no item. The
// throughput is set by the state update between the input handshake and
// the result register: one byte per cycle while the output is not stalled.
module rsp_packet_receive_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [15:8] computed_sum
    output logic        m_axis_tlast,   // is_end
    output logic        m_axis_tuser    // checksum_ok
);
    import rspchk_pkg::*;

    `include "assert_macros.svh"

    t_state     r_state;
    t_state     n_state;
    t_result    step_res;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic [7:0] r_out_sum;
    logic       r_out_last;
    logic       r_out_ok;
    logic       in_acc;
    logic       out_free;

    rspchk_parser u_parser (
        .i_byte   (s_axis_tdata),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (step_res)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = out_free;
    assign in_acc        = s_axis_tvalid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= in_acc && step_res.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && step_res.valid) begin
            r_out_byte <= step_res.out_byte;
            r_out_sum  <= step_res.sum;
            r_out_last <= step_res.is_end;
            r_out_ok   <= step_res.ok;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_sum, r_out_byte};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_ok;

    `ASSERT_IMPLIES(a_ok_only_at_end, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "checksum_ok set on a payload item")
    `ASSERT_IMPLIES(a_verdict_byte, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, (m_axis_tuser && m_axis_tdata[7:0] == CH_ACK) || (!m_axis_tuser && m_axis_tdata[7:0] == CH_NACK), "verdict byte does not match checksum_ok")
    `ASSERT_NEXT(a_idle_after_end, i_clk, i_rst_n, in_acc && step_res.is_end, r_state.phase == PH_IDLE && m_axis_tvalid && m_axis_tlast, "verdict did not return to idle")
    `ASSERT_NEXT(a_start_clears_sum, i_clk, i_rst_n, in_acc && r_state.phase == PH_IDLE && s_axis_tdata == CH_START, r_state.sum == 8'h00 && r_state.phase == PH_PAYLOAD, "start marker did not clear sum")

endmodule

// File: rtl/core/rspchk_parser.sv
// ---------------------------------------------------------------------------
// rspchk_parser
// Per-byte framing step: next phase, running sum and checksum digit, plus
// the result item caused by the byte, if any.
// ---------------------------------------------------------------------------
module rspchk_parser (
    input  logic [7:0]          i_byte,
    input  rspchk_pkg::t_state  i_state,
    output rspchk_pkg::t_state  o_state,
    output rspchk_pkg::t_result o_result
);
    import rspchk_pkg::*;

    logic [4:0] hex;
    logic [7:0] sum_add;
    logic       match;

    assign hex     = hex_value(i_byte);
    assign sum_add = i_state.sum + i_byte;
    assign match   = ({i_state.high, hex[3:0]} == i_state.sum);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        unique case (i_state.phase)
            PH_IDLE: begin
                if (i_byte == CH_START) begin
                    o_state.sum   = 8'h00;
                    o_state.phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (i_byte == CH_END) begin
                    o_state.phase = PH_HIGH;
                end else begin
                    o_state.sum       = sum_add;
                    o_result.valid    = 1'b1;
                    o_result.out_byte = i_byte;
                    o_result.sum      = sum_add;
                end
            end
            PH_HIGH: begin
                if (!hex[4]) begin
                    o_state.high  = hex[3:0];
                    o_state.phase = PH_LOW;
                end
            end
            PH_LOW: begin
                if (!hex[4]) begin
                    o_state.phase     = PH_IDLE;
                    o_result.valid    = 1'b1;
                    o_result.out_byte = match ? CH_ACK : CH_NACK;
                    o_result.is_end   = 1'b1;
                    o_result.ok       = match;
                    o_result.sum      = i_state.sum;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule
